@@ hdl/cmac_pkg.sv @@
// Package for the AES-128 CMAC engine: payload structs, state codes, AES helpers.
// No dependencies.
package cmac_pkg;

   localparam int BlockBits = 128;
   localparam int NumRounds = 10;
   localparam int FifoDepth = 2;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [4:0]  valid_bytes;
      logic        last_block;
   } req_type;

   typedef struct packed {
      logic [63:0] mac_high;
      logic [63:0] mac_low;
   } rsp_type;

   // classified word handed from front to back
   typedef struct packed {
      logic [127:0] data;   // padded block (subkey applied in back)
      logic         last;
      logic         full_blk;
   } work_type;

   typedef enum logic [1:0] {
      CSR_KEY_HIGH = 2'd0,
      CSR_KEY_LOW  = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEYEXP,
      ST_SUBKEY,
      ST_START,
      ST_ROUND,
      ST_OUTPUT
   } state_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
      8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
      8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
      8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
      8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
      8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
      8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
      8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
      8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
      8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
      8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
      8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
      8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
      8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
      8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
      8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
      8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1B;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

   // next 128-bit round key from the previous one
   function automatic logic [127:0] next_rkey(input logic [127:0] k, input logic [3:0] r);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // SubBytes, ShiftRows and optionally MixColumns; byte 0 is bits 127:120
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
      logic [7:0] b [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            t[4*c + r] = sbox(b[4*((c + r) & 3) + r]);
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
      return o;
   endfunction

   function automatic logic [127:0] dbl(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
   endfunction

endpackage

@@ hdl/aes128_cmac_engine.sv @@
// AES-128 CMAC engine top level: key registers, front end and back end.
// Depends on cmac_pkg, cmac_front, cmac_back.
//
// Usage:
//   Write the key through csr_ (index 0 key bytes 0..7, index 1 bytes 8..15)
//   while the engine is idle. Push message blocks on req_ (push/full), with
//   last_block set on the final one and valid_bytes giving its length.
//   One MAC word appears on rsp_ per message (empty/pop).
// Sequence:
//   Each block passes through the back end in order: the idle state that
//   sees the queued word, a load state that takes it, ten AES rounds (one
//   round per cycle through a single round unit) and an output state. The
//   first block after reset or a key write first passes through round key
//   expansion and the subkey encryption.
//   A two-word queue lets the front accept blocks while the back end works.
// Reset clears the chain, the queue and the subkey status. When the
// receiver does not pop, the result is held and the back end stalls
// before starting the next block.
module aes128_cmac_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  cmac_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output cmac_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data
);
   import cmac_pkg::*;

   logic [63:0] key_hi_ff, key_lo_ff;
   logic        key_wr;
   logic        wq_valid, wq_take;
   work_type    wq_data;

   assign csr_ready = 1'b1;
   assign key_wr = csr_valid && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW);

   // hold key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index == CSR_KEY_HIGH) key_hi_ff <= csr_data;
         if (csr_index == CSR_KEY_LOW) key_lo_ff <= csr_data;
      end
   end

   cmac_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data,
      .wq_valid, .wq_take, .wq_data
   );

   cmac_back u_back (
      .clock, .reset, .key({key_hi_ff, key_lo_ff}), .key_wr,
      .wq_valid, .wq_take, .wq_data, .rsp_empty, .rsp_pop, .rsp_data
   );
endmodule

@@ hdl/cmac_front.sv @@
// Front end of the CMAC engine: accepts request words, pads the last block,
// and queues classified words for the back end. Depends on cmac_pkg.
module cmac_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  cmac_pkg::req_type  req_data,
   output logic               wq_valid,
   input  logic               wq_take,
   output cmac_pkg::work_type wq_data
);
   import cmac_pkg::*;

   work_type   mem_ff [FifoDepth];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   work_type   cls;
   logic       push_ok;
   logic [4:0] nv;

   // classify and pad
   always_comb begin
      nv = (req_data.valid_bytes > 5'd16) ? 5'd16 : req_data.valid_bytes;
      cls.data = {req_data.block_high, req_data.block_low};
      cls.last = req_data.last_block;
      cls.full_blk = (nv == 5'd16);
      if (req_data.last_block && nv != 5'd16) begin
         for (int j = 0; j < 16; j++) begin
            if (j == int'(nv)) cls.data[127 - 8*j -: 8] = 8'h80;
            else if (j > int'(nv)) cls.data[127 - 8*j -: 8] = 8'h00;
         end
      end
   end

   assign req_full = (cnt_ff == 2'(FifoDepth));
   assign push_ok  = req_push && !req_full;
   assign wq_valid = (cnt_ff != 2'd0);
   assign wq_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(push_ok);
      rd_ptr_in = rd_ptr_ff + 1'(wq_take);
      cnt_in = cnt_ff + 2'(push_ok) - 2'(wq_take);
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   // store word
   always_ff @(posedge clock) begin
      if (push_ok) mem_ff[wr_ptr_ff] <= cls;
   end
endmodule

@@ hdl/cmac_back.sv @@
// Back end of the CMAC engine: key expansion, subkey derivation, one AES
// round per cycle on the chaining value, and a result register. Depends on cmac_pkg.
module cmac_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [127:0]       key,
   input  logic               key_wr,
   input  logic               wq_valid,
   output logic               wq_take,
   input  cmac_pkg::work_type wq_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output cmac_pkg::rsp_type  rsp_data
);
   import cmac_pkg::*;

   state_type    state_ff, state_in;
   logic [127:0] rk_mem [NumRounds + 1];
   logic [127:0] st_ff, st_in;
   logic [127:0] chain_ff, chain_in;
   logic [127:0] k1_ff, k1_in;
   logic [127:0] kx_ff;
   logic [3:0]   rnd_ff, rnd_in;
   logic         ready_ff, ready_in;
   logic         last_ff, last_in;
   logic         sk_ff, sk_in;
   logic         out_v_ff, out_v_in;
   rsp_type      out_ff, out_in;
   logic [127:0] rk_rd, rnd_out, blk;

   assign rk_rd = rk_mem[rnd_ff];
   assign rnd_out = aes_round(st_ff, rnd_ff != 4'(NumRounds)) ^ rk_rd;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (wq_valid && !out_v_ff) state_in = ready_ff ? ST_START : ST_KEYEXP;
         ST_KEYEXP: if (rnd_ff == 4'(NumRounds)) state_in = ST_SUBKEY;
         ST_SUBKEY: state_in = ST_ROUND;
         ST_START:  state_in = ST_ROUND;
         ST_ROUND:  if (rnd_ff == 4'(NumRounds)) state_in = sk_ff ? ST_START : ST_OUTPUT;
         ST_OUTPUT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      st_in = st_ff;
      chain_in = chain_ff;
      k1_in = k1_ff;
      rnd_in = rnd_ff;
      ready_in = ready_ff;
      last_in = last_ff;
      sk_in = sk_ff;
      out_in = out_ff;
      out_v_in = out_v_ff && !rsp_pop;
      wq_take = 1'b0;
      blk = wq_data.data ^ (!wq_data.last ? 128'h0 :
            (wq_data.full_blk ? k1_ff : dbl(k1_ff)));
      case (state_ff)
         ST_IDLE:   rnd_in = 4'd0;
         ST_KEYEXP: rnd_in = rnd_ff + 4'd1;
         ST_SUBKEY: begin
            st_in = rk_mem[0];
            rnd_in = 4'd1;
            sk_in = 1'b1;
         end
         ST_START: begin
            st_in = chain_ff ^ blk ^ rk_mem[0];
            last_in = wq_data.last;
            rnd_in = 4'd1;
            sk_in = 1'b0;
            ready_in = 1'b1;
            wq_take = 1'b1;
         end
         ST_ROUND: begin
            st_in = rnd_out;
            rnd_in = rnd_ff + 4'd1;
            if (rnd_ff == 4'(NumRounds)) begin
               if (sk_ff) k1_in = dbl(rnd_out);
               else if (last_ff) begin
                  chain_in = '0;
                  out_in = rnd_out;
                  out_v_in = 1'b1;
               end else chain_in = rnd_out;
            end
         end
         ST_OUTPUT: ;
         default: ;
      endcase
      if (key_wr) ready_in = 1'b0;
   end

   // advance control state; every word passes through the output state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chain_ff <= '0;
         ready_ff <= 1'b0;
         out_v_ff <= 1'b0;
         rnd_ff <= 4'd0;
         sk_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         ready_ff <= ready_in;
         out_v_ff <= out_v_in;
         rnd_ff <= rnd_in;
         sk_ff <= sk_in;
         last_ff <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      st_ff <= st_in;
      k1_ff <= k1_in;
      out_ff <= out_in;
   end

   // expand round keys, one per cycle
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) kx_ff <= key;
      else if (state_ff == ST_KEYEXP) begin
         if (rnd_ff == 4'd0) begin
            rk_mem[0] <= kx_ff;
         end else begin
            rk_mem[rnd_ff] <= next_rkey(kx_ff, rnd_ff);
            kx_ff <= next_rkey(kx_ff, rnd_ff);
         end
      end
   end

   assign rsp_empty = !out_v_ff;
   assign rsp_data = out_ff;
endmodule

@@ test/aes128_cmac_engine_test.sv @@
// Self-checking testbench for the AES-128 CMAC engine: drives message words and key writes,
// predicts each MAC with its own AES-128 model and compares it with the engine output.
// Depends on cmac_pkg and the aes128_cmac_engine RTL.
`timescale 1ns / 100ps

module aes128_cmac_engine_test;
   import cmac_pkg::*;

   localparam int CycleLimit = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [63:0] csr_data = '0;

   aes128_cmac_engine uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [127:0] key_reg;
   logic [127:0] chain;
   logic [127:0] k1, k2;
   logic [31:0] rk_words [44];
   logic keys_valid;
   rsp_type mac_queue [$];

   int errors = 0;
   int words_sent = 0;
   int macs_seen = 0;
   int cycles = 0;
   int hold_cycles = 0;

   // lookup table built once
   logic [7:0] sub_table [256];

   function automatic logic [7:0] gf2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p, v;
      p = 8'h00;
      v = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ v;
         v = gf2(v);
      end
      return p;
   endfunction

   // S-box from the field inverse plus the affine map
   task automatic build_sub_table();
      logic [7:0] inv, x, y;
      for (int a = 0; a < 256; a++) begin
         inv = 8'h00;
         for (int c = 1; c < 256; c++) begin
            if (gf_mul(a[7:0], c[7:0]) == 8'h01) inv = c[7:0];
         end
         x = inv;
         y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]}
             ^ 8'h63;
         sub_table[a] = y;
      end
   endtask

   function automatic void expand_round_keys();
      logic [31:0] t;
      logic [7:0] rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) rk_words[i] = key_reg[127 - 32*i -: 32];
      for (int i = 4; i < 44; i++) begin
         t = rk_words[i-1];
         if (i % 4 == 0) begin
            t = {sub_table[t[23:16]] ^ rc, sub_table[t[15:8]], sub_table[t[7:0]],
                 sub_table[t[31:24]]};
            rc = gf2(rc);
         end
         rk_words[i] = rk_words[i-4] ^ t;
      end
   endfunction

   function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] o;
      for (int i = 0; i < 16; i++) s[i] = pt[127 - 8*i -: 8];
      for (int rnd = 0; rnd <= 10; rnd++) begin
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) t[4*c + r] = sub_table[s[4*((c + r) & 3) + r]];
            if (rnd < 10) begin
               for (int c = 0; c < 4; c++) begin
                  a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
                  al = a0 ^ a1 ^ a2 ^ a3;
                  t[4*c]   = a0 ^ al ^ gf2(a0 ^ a1);
                  t[4*c+1] = a1 ^ al ^ gf2(a1 ^ a2);
                  t[4*c+2] = a2 ^ al ^ gf2(a2 ^ a3);
                  t[4*c+3] = a3 ^ al ^ gf2(a3 ^ a0);
               end
            end
            s = t;
         end
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) s[4*c + r] ^= rk_words[rnd*4 + c][31 - 8*r -: 8];
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = s[i];
      return o;
   endfunction

   function automatic logic [127:0] shift_subkey(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
   endfunction

   // advance the chain by one message word, queue a MAC on the last one
   function automatic void predict_mac(input req_type w);
      logic [127:0] blk, l;
      int nvalid;
      rsp_type r;
      if (!keys_valid) begin
         expand_round_keys();
         l = aes_encrypt('0);
         k1 = shift_subkey(l);
         k2 = shift_subkey(k1);
         keys_valid = 1'b1;
      end
      blk = {w.block_high, w.block_low};
      if (!w.last_block) begin
         chain = aes_encrypt(chain ^ blk);
         return;
      end
      nvalid = w.valid_bytes;
      if (nvalid >= 16) blk ^= k1;
      else begin
         for (int j = 0; j < 16; j++) begin
            if (j == nvalid) blk[127 - 8*j -: 8] = 8'h80;
            else if (j > nvalid) blk[127 - 8*j -: 8] = 8'h00;
         end
         blk ^= k2;
      end
      {r.mac_high, r.mac_low} = aes_encrypt(chain ^ blk);
      mac_queue.push_back(r);
      chain = '0;
   endfunction

   // send one message word, with the predictor updated on acceptance
   task automatic send_word(input req_type w);
      req_push = 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_full);
      predict_mac(w);
      words_sent++;
      @(negedge clock);
      req_push = 1'b0;
   endtask

   // random gap between bursts
   int burst_left = 0;
   task automatic send_paced(input req_type w);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      send_word(w);
   endtask

   task automatic wait_drained();
      while (mac_queue.size() != 0) @(negedge clock);
      // a non-last word may still be in the engine
      repeat (60) @(negedge clock);
   endtask

   task automatic write_key(input csr_index_type idx, input logic [63:0] value);
      csr_valid = 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_KEY_HIGH) key_reg[127:64] = value;
      else key_reg[63:0] = value;
      keys_valid = 1'b0;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic req_type make_word(input logic last, input int nvalid);
      req_type w;
      w.block_high = {$urandom, $urandom};
      w.block_low = {$urandom, $urandom};
      w.valid_bytes = nvalid[4:0];
      w.last_block = last;
      return w;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // receiver: stall pattern, with a long hold-off on request
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 3) != 0);
      end
   end

   // compare each popped MAC with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         macs_seen++;
         if (mac_queue.size() == 0) begin
            $display("%0t: unexpected MAC %h_%h", $realtime, rsp_data.mac_high,
                     rsp_data.mac_low);
            errors++;
         end else begin
            if (rsp_data.mac_high !== mac_queue[0].mac_high) begin
               $display("%0t: mac_high expected %h actual %h", $realtime,
                        mac_queue[0].mac_high, rsp_data.mac_high);
               errors++;
            end
            if (rsp_data.mac_low !== mac_queue[0].mac_low) begin
               $display("%0t: mac_low expected %h actual %h", $realtime,
                        mac_queue[0].mac_low, rsp_data.mac_low);
               errors++;
            end
            void'(mac_queue.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("aes128_cmac_engine_test: done, errors");
         $finish;
      end
   end

   // known-answer vectors from the standard key, then the corner cases
   task automatic test_directed();
      // reset key of zero: empty message first
      send_word('{block_high: 64'h0, block_low: 64'h0, valid_bytes: 5'd0, last_block: 1'b1});
      wait_drained();
      write_key(CSR_KEY_HIGH, 64'h2b7e151628aed2a6);
      write_key(CSR_KEY_LOW, 64'habf7158809cf4f3c);
      send_word('{block_high: 64'h0, block_low: 64'h0, valid_bytes: 5'd0, last_block: 1'b1});
      send_word('{block_high: 64'h6bc1bee22e409f96, block_low: 64'he93d7e117393172a,
                  valid_bytes: 5'd16, last_block: 1'b1});
      // all ones and all zeros, full and partial, oversized count
      send_word('{block_high: '1, block_low: '1, valid_bytes: 5'd31, last_block: 1'b1});
      send_word('{block_high: '1, block_low: '1, valid_bytes: 5'd15, last_block: 1'b1});
      send_word('{block_high: '1, block_low: '1, valid_bytes: 5'd1, last_block: 1'b0});
      send_word('{block_high: '1, block_low: '1, valid_bytes: 5'd0, last_block: 1'b1});
      send_word('{block_high: '0, block_low: '0, valid_bytes: 5'd17, last_block: 1'b0});
      send_word('{block_high: '0, block_low: '1, valid_bytes: 5'd8, last_block: 1'b1});
      for (int n = 1; n <= 16; n += 5) send_word(make_word(1'b1, n));
      wait_drained();
      // extreme keys; a key change between the words of one message
      write_key(CSR_KEY_HIGH, '1);
      write_key(CSR_KEY_LOW, '1);
      send_word(make_word(1'b0, 0));
      wait_drained();
      write_key(CSR_KEY_LOW, '0);
      send_word(make_word(1'b1, 7));
      wait_drained();
   endtask

   // random messages under the current key
   task automatic test_random_messages(input int n_words);
      int len, sent;
      sent = 0;
      while (sent < n_words) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 3);
         for (int i = 1; i < len; i++) send_paced(make_word(1'b0, $urandom_range(0, 31)));
         send_paced(make_word(1'b1, ($urandom_range(0, 2) == 0) ? 16 : $urandom_range(0, 31)));
         sent += len;
      end
   endtask

   // receiver holds off while the sender keeps pushing
   task automatic test_backpressure();
      @(negedge clock);
      hold_cycles <= 400;
      for (int i = 0; i < 12; i++) send_word(make_word(1'b1, $urandom_range(0, 16)));
      wait_drained();
   endtask

   initial begin
      key_reg = '0;
      chain = '0;
      keys_valid = 1'b0;
      build_sub_table();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      for (int phase = 0; phase < 6; phase++) begin
         write_key(CSR_KEY_HIGH, rand64());
         write_key(CSR_KEY_LOW, rand64());
         test_random_messages(270);
         wait_drained();
      end
      test_backpressure();

      wait_drained();
      $display("covered %0d words and %0d MACs over directed, random, key-change and",
               words_sent, macs_seen);
      $display("stalled-receiver cases");
      if (errors == 0 && mac_queue.size() == 0) begin
         $display("aes128_cmac_engine_test: done, clean");
      end else begin
         $display("aes128_cmac_engine_test: done, errors");
      end
      $finish;
   end

endmodule
